FILE: rtl/piecewise_cubic_motion_evaluator_unit_macros.svh
// Assertion macros shared by the checker of the motion evaluator.
`ifndef PIECEWISE_CUBIC_MOTION_EVALUATOR_UNIT_MACROS_SVH
`define PIECEWISE_CUBIC_MOTION_EVALUATOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define PCME_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define PCME_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pcme_pkg.sv
// Shared types, constants and codes of the piecewise cubic motion evaluator.
package pcme_pkg;

	// Table size and derived widths.
	localparam int MAX_SEGMENTS = 16;
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	// Wide arithmetic: six 32-bit limbs.
	localparam int LIMBS = 6;
	localparam int WIDE_W = 32 * LIMBS;

	// Operation codes.
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_EVAL   = 2'd1;
	localparam logic [1:0] OP_TRIM   = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// Status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_NOHIT = 2'd2;

	// One stored segment, 256 bits.
	typedef struct packed {
		logic [31:0] t_begin;
		logic [31:0] t_end;
		logic [47:0] position;
		logic [47:0] velocity;
		logic [47:0] acceleration;
		logic [47:0] jerk;
	} seg_t;

	// Request from the sequencer to the evaluation unit.
	typedef struct packed {
		logic        start;
		logic [31:0] dt;
		logic [47:0] position;
		logic [47:0] velocity;
		logic [47:0] acceleration;
		logic [47:0] jerk;
	} eval_req_t;

	// Answer of the evaluation unit.
	typedef struct packed {
		logic        done;
		logic [47:0] position;
		logic [47:0] velocity;
		logic [47:0] acceleration;
	} eval_rsp_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_SCAN,
		C_EVAL,
		C_RESP
	} ctl_state_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_MUL,
		E_PREP,
		E_DIV
	} eval_state_t;

endpackage

FILE: rtl/pcme_if.sv
// Request and response channel interfaces of the motion evaluator.
interface pcme_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] query_time;
	logic [31:0] seg_start_time;
	logic [31:0] seg_end_time;
	logic signed [47:0] seg_position;
	logic signed [47:0] seg_velocity;
	logic signed [47:0] seg_acceleration;
	logic signed [47:0] seg_jerk;
	logic [4:0]  keep_count;

	modport source (output valid, operation, query_time, seg_start_time, seg_end_time,
		seg_position, seg_velocity, seg_acceleration, seg_jerk, keep_count,
		input ready);
	modport sink (input valid, operation, query_time, seg_start_time, seg_end_time,
		seg_position, seg_velocity, seg_acceleration, seg_jerk, keep_count,
		output ready);
endinterface

interface pcme_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic signed [47:0] position;
	logic signed [47:0] velocity;
	logic signed [47:0] acceleration;
	logic [3:0]  segment_index;

	modport source (output valid, status, position, velocity, acceleration, segment_index,
		input ready);
	modport sink (input valid, status, position, velocity, acceleration, segment_index,
		output ready);
endinterface

FILE: rtl/pcme_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pcme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/pcme_eval.sv
// Evaluation unit: limb-serial Horner products, rounding, saturation and divide by six.
module pcme_eval (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcme_pkg::eval_req_t  ereq,
	output pcme_pkg::eval_rsp_t  ersp
);

	localparam int W = pcme_pkg::WIDE_W;
	localparam logic signed [W-1:0] POS_BIAS = W'(3) << 48;
	localparam logic signed [W-1:0] POS_MIN  = -(W'(3) << 48);
	localparam logic signed [W-1:0] POS_MAX  = (W'(3) << 48) - W'(1);
	localparam logic signed [W-1:0] VEL_HALF = W'(1) << 32;
	localparam logic signed [W-1:0] ACC_HALF = W'(1) << 15;
	localparam logic [17:0] RECIP3 = 18'd174763;
	localparam logic [47:0] SAT_MIN = 48'h8000_0000_0000;
	localparam logic [47:0] SAT_MAX = 48'h7FFF_FFFF_FFFF;

	pcme_pkg::eval_state_t state_q, state_d;

	logic [1:0]  pass_q;
	logic [2:0]  limb_q;
	logic [31:0] carry_q;
	logic [31:0] dt_q;
	logic [W-1:0] mx_q;
	logic [W-1:0] mres_q;
	logic signed [W-1:0] x1_q;
	logic signed [W-1:0] npos_q;
	logic [47:0] p_q, v_q, a_q;
	logic [47:0] pos_q, vel_q, acc_q;
	logic        done_q;
	logic        neg_sat_q, pos_sat_q;
	logic [63:0] div_num_q;
	logic [63:0] div_quo_q;
	logic [1:0]  div_rem_q;
	logic [1:0]  div_cnt_q;

	logic [63:0] prod;
	logic [W-1:0] pfin;
	logic        last_limb;
	logic signed [W-1:0] p_w, v_w, a_w, j_w;
	logic signed [W-1:0] pos_m, pos_u;
	logic [17:0] div_cur;
	logic [36:0] div_mul;
	logic [15:0] div_qt;
	logic [17:0] div_left;
	logic [63:0] quo_new;

	// Saturate a wide signed value to 48 bits.
	function automatic logic [47:0] sat48(input logic signed [W-1:0] w);
		logic fits;
		fits = (&w[W-1:47]) || !(|w[W-1:47]);
		if (fits) begin
			return w[47:0];
		end
		return w[W-1] ? SAT_MIN : SAT_MAX;
	endfunction

	// Sign-extended segment coefficients.
	assign p_w = W'($signed(p_q));
	assign v_w = W'($signed(v_q));
	assign a_w = W'($signed(a_q));
	assign j_w = W'($signed(ereq.jerk));

	// One 32x32 limb product per cycle; the full product appears on the last limb.
	assign prod = 64'(mx_q[31:0]) * 64'(dt_q) + 64'(carry_q);
	assign pfin = {prod[31:0], mres_q[W-1:32]};
	assign last_limb = (limb_q == 3'(pcme_pkg::LIMBS - 1));

	// Rounded position before the final divide by six.
	assign pos_m = (npos_q + POS_BIAS) >>> 48;
	assign pos_u = pos_m + POS_BIAS;

	// One divide-by-three digit step: 16 quotient bits via reciprocal multiply.
	assign div_cur = {div_rem_q, div_num_q[63:48]};
	assign div_mul = 37'(div_cur) * 37'(RECIP3);
	assign div_qt = div_mul[34:19];
	assign div_left = div_cur - 18'(div_qt) * 18'd3;
	assign quo_new = {div_quo_q[47:0], div_qt};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcme_pkg::E_IDLE: begin
				if (ereq.start) begin
					state_d = pcme_pkg::E_MUL;
				end
			end
			pcme_pkg::E_MUL: begin
				if (last_limb && pass_q == 2'd3) begin
					state_d = pcme_pkg::E_PREP;
				end
			end
			pcme_pkg::E_PREP: begin
				state_d = pcme_pkg::E_DIV;
			end
			pcme_pkg::E_DIV: begin
				if (div_cnt_q == 2'd3) begin
					state_d = pcme_pkg::E_IDLE;
				end
			end
			default: begin
				state_d = pcme_pkg::E_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcme_pkg::E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters and the completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			pass_q <= 2'd0;
			limb_q <= 3'd0;
			div_cnt_q <= 2'd0;
		end else begin
			done_q <= (state_q == pcme_pkg::E_DIV) && (div_cnt_q == 2'd3);
			case (state_q)
				pcme_pkg::E_IDLE: begin
					pass_q <= 2'd0;
					limb_q <= 3'd0;
				end
				pcme_pkg::E_MUL: begin
					if (last_limb) begin
						limb_q <= 3'd0;
						pass_q <= pass_q + 2'd1;
					end else begin
						limb_q <= limb_q + 3'd1;
					end
				end
				pcme_pkg::E_PREP: begin
					div_cnt_q <= 2'd0;
				end
				pcme_pkg::E_DIV: begin
					div_cnt_q <= div_cnt_q + 2'd1;
				end
				default: begin
					pass_q <= 2'd0;
				end
			endcase
		end
	end

	// Datapath: Horner passes j*dt, (x1+3a)*dt, (..+6v)*dt, (x1+2a)*dt.
	always_ff @(posedge clk) begin
		case (state_q)
			pcme_pkg::E_IDLE: begin
				if (ereq.start) begin
					dt_q <= ereq.dt;
					p_q <= ereq.position;
					v_q <= ereq.velocity;
					a_q <= ereq.acceleration;
					mx_q <= j_w;
					carry_q <= 32'd0;
				end
			end
			pcme_pkg::E_MUL: begin
				mres_q <= pfin;
				if (last_limb) begin
					carry_q <= 32'd0;
					case (pass_q)
						2'd0: begin
							x1_q <= $signed(pfin);
							mx_q <= $signed(pfin) + ((a_w + (a_w <<< 1)) <<< 16);
						end
						2'd1: begin
							mx_q <= $signed(pfin) + (((v_w <<< 2) + (v_w <<< 1)) <<< 32);
						end
						2'd2: begin
							npos_q <= $signed(pfin) + (((p_w <<< 2) + (p_w <<< 1)) <<< 48);
							mx_q <= x1_q + (a_w <<< 17);
						end
						default: begin
							vel_q <= sat48(($signed(pfin) + (v_w <<< 33) + VEL_HALF) >>> 33);
						end
					endcase
				end else begin
					mx_q <= mx_q >> 32;
					carry_q <= prod[63:32];
				end
			end
			pcme_pkg::E_PREP: begin
				acc_q <= sat48((x1_q + (a_w <<< 16) + ACC_HALF) >>> 16);
				neg_sat_q <= (pos_m < POS_MIN);
				pos_sat_q <= (pos_m > POS_MAX);
				div_num_q <= {14'd0, pos_u[50:1]};
				div_rem_q <= 2'd0;
				div_quo_q <= 64'd0;
			end
			pcme_pkg::E_DIV: begin
				div_num_q <= div_num_q << 16;
				div_rem_q <= div_left[1:0];
				div_quo_q <= quo_new;
				if (div_cnt_q == 2'd3) begin
					if (neg_sat_q) begin
						pos_q <= SAT_MIN;
					end else if (pos_sat_q) begin
						pos_q <= SAT_MAX;
					end else begin
						pos_q <= {~quo_new[47], quo_new[46:0]};
					end
				end
			end
			default: begin
				mx_q <= mx_q;
			end
		endcase
	end

	assign ersp.done = done_q;
	assign ersp.position = pos_q;
	assign ersp.velocity = vel_q;
	assign ersp.acceleration = acc_q;

endmodule

FILE: rtl/piecewise_cubic_motion_evaluator_unit.sv
// Top level of the piecewise cubic motion evaluator: segment memory, scan and response.
//
// Segments live in a 16-entry, 256-bit synchronous RAM in append order; an append
// writes the next free entry, a trim only lowers the segment count, and an evaluate
// scans the stored entries from index 0, one RAM read per cycle, until the first
// segment whose half-open time span holds the query time. A hit then goes to the
// evaluation unit: four 192-by-32-bit products done one 32x32 limb per cycle, a
// rounding and saturation step, four divide-by-three digit steps and a hand-off
// to the response. Only one request is in flight; a finished response waits in the
// output register while the next request is taken. The segment memory is not
// cleared at reset.
module piecewise_cubic_motion_evaluator_unit (
	input  logic        clk,
	input  logic        arst_n,
	pcme_req_if.sink    req,
	pcme_rsp_if.source  rsp
);

	localparam int CW = pcme_pkg::CNT_W;
	localparam int IW = pcme_pkg::IDX_W;

	pcme_pkg::ctl_state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] idx_s1;
	logic          pend_s1;
	logic [31:0]   query_q;
	logic [1:0]    res_status_q;
	logic [3:0]    res_idx_q;
	logic          res_motion_q;

	logic          rsp_valid_q;
	logic [1:0]    rsp_status_q;
	logic [47:0]   rsp_pos_q, rsp_vel_q, rsp_acc_q;
	logic [3:0]    rsp_idx_q;

	logic          accept;
	logic          ram_we, ram_re;
	logic [1:0]    acc_status;
	pcme_pkg::seg_t wseg, rseg;
	logic          hit, last_probe, out_free;
	pcme_pkg::eval_req_t ereq;
	pcme_pkg::eval_rsp_t ersp;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == pcme_pkg::C_IDLE);

	// Segment store.
	assign wseg.t_begin = req.seg_start_time;
	assign wseg.t_end = req.seg_end_time;
	assign wseg.position = req.seg_position;
	assign wseg.velocity = req.seg_velocity;
	assign wseg.acceleration = req.seg_acceleration;
	assign wseg.jerk = req.seg_jerk;
	assign ram_we = accept && req.operation == pcme_pkg::OP_APPEND
		&& count_q != CW'(pcme_pkg::MAX_SEGMENTS);
	assign ram_re = (state_q == pcme_pkg::C_SCAN) && (scan_q < count_q);

	pcme_ram #(
		.WIDTH($bits(pcme_pkg::seg_t)),
		.DEPTH(pcme_pkg::MAX_SEGMENTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata (wseg),
		.re    (ram_re),
		.raddr (scan_q[IW-1:0]),
		.rdata (rseg)
	);

	// Status known at acceptance: a full table or an empty table.
	always_comb begin
		acc_status = pcme_pkg::STATUS_OK;
		case (req.operation)
			pcme_pkg::OP_APPEND: begin
				if (count_q == CW'(pcme_pkg::MAX_SEGMENTS)) begin
					acc_status = pcme_pkg::STATUS_FULL;
				end
			end
			pcme_pkg::OP_EVAL: begin
				if (count_q == '0) begin
					acc_status = pcme_pkg::STATUS_NOHIT;
				end
			end
			default: begin
				acc_status = pcme_pkg::STATUS_OK;
			end
		endcase
	end

	// Hit test on the entry read in the previous cycle.
	assign hit = pend_s1 && (query_q >= rseg.t_begin) && (query_q < rseg.t_end);
	assign last_probe = pend_s1 && (CW'(idx_s1 + 1'b1) == count_q);

	assign ereq.start = (state_q == pcme_pkg::C_SCAN) && hit;
	assign ereq.dt = query_q - rseg.t_begin;
	assign ereq.position = rseg.position;
	assign ereq.velocity = rseg.velocity;
	assign ereq.acceleration = rseg.acceleration;
	assign ereq.jerk = rseg.jerk;

	pcme_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.ereq   (ereq),
		.ersp   (ersp)
	);

	assign out_free = !rsp_valid_q || rsp.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcme_pkg::C_IDLE: begin
				if (accept) begin
					if (req.operation == pcme_pkg::OP_EVAL && count_q != '0) begin
						state_d = pcme_pkg::C_SCAN;
					end else begin
						state_d = pcme_pkg::C_RESP;
					end
				end
			end
			pcme_pkg::C_SCAN: begin
				if (hit) begin
					state_d = pcme_pkg::C_EVAL;
				end else if (last_probe) begin
					state_d = pcme_pkg::C_RESP;
				end
			end
			pcme_pkg::C_EVAL: begin
				if (ersp.done) begin
					state_d = pcme_pkg::C_RESP;
				end
			end
			pcme_pkg::C_RESP: begin
				if (out_free) begin
					state_d = pcme_pkg::C_IDLE;
				end
			end
			default: begin
				state_d = pcme_pkg::C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcme_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Segment count, scan pointer and pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q <= '0;
			pend_s1 <= 1'b0;
			res_status_q <= pcme_pkg::STATUS_OK;
			res_idx_q <= 4'd0;
			res_motion_q <= 1'b0;
		end else begin
			case (state_q)
				pcme_pkg::C_IDLE: begin
					scan_q <= '0;
					pend_s1 <= 1'b0;
					res_status_q <= acc_status;
					res_idx_q <= 4'd0;
					res_motion_q <= 1'b0;
					if (ram_we) begin
						count_q <= count_q + 1'b1;
					end else if (accept && req.operation == pcme_pkg::OP_TRIM
							&& req.keep_count < count_q) begin
						count_q <= CW'(req.keep_count);
					end
				end
				pcme_pkg::C_SCAN: begin
					pend_s1 <= ram_re;
					if (ram_re) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						res_idx_q <= 4'(idx_s1);
						res_motion_q <= 1'b1;
					end else if (last_probe) begin
						res_status_q <= pcme_pkg::STATUS_NOHIT;
					end
				end
				default: begin
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Scan index pipeline and query time.
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (accept) begin
			query_q <= req.query_time;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == pcme_pkg::C_RESP && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pcme_pkg::C_RESP && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_idx_q <= res_idx_q;
			rsp_pos_q <= res_motion_q ? ersp.position : 48'd0;
			rsp_vel_q <= res_motion_q ? ersp.velocity : 48'd0;
			rsp_acc_q <= res_motion_q ? ersp.acceleration : 48'd0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.position = rsp_pos_q;
	assign rsp.velocity = rsp_vel_q;
	assign rsp.acceleration = rsp_acc_q;
	assign rsp.segment_index = rsp_idx_q;

endmodule

FILE: rtl/pcme_checker.sv
// Port-level checker of the motion evaluator and its binding to the top level.
`include "piecewise_cubic_motion_evaluator_unit_macros.svh"

module pcme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [47:0] rsp_position,
	input logic [47:0] rsp_velocity,
	input logic [47:0] rsp_acceleration,
	input logic [3:0]  rsp_segment_index
);

	// A response that waits keeps its status.
	`PCME_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "response dropped or changed while stalled")

	// Only one request is worked on at a time.
	`PCME_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while another is in flight")

	// A response with a failure status carries zero motion and a zero segment index.
	`PCME_ASSERT_IMP(a_zero_on_fail, rsp_valid && rsp_status != pcme_pkg::STATUS_OK, rsp_position == 48'd0 && rsp_velocity == 48'd0 && rsp_acceleration == 48'd0 && rsp_segment_index == 4'd0, "nonzero motion fields on a failed request")

	// The unused status code never appears.
	`PCME_ASSERT_IMP(a_status_code, rsp_valid, rsp_status <= pcme_pkg::STATUS_NOHIT, "undefined status code")

endmodule

bind piecewise_cubic_motion_evaluator_unit pcme_checker u_pcme_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_position      (rsp.position),
	.rsp_velocity      (rsp.velocity),
	.rsp_acceleration  (rsp.acceleration),
	.rsp_segment_index (rsp.segment_index)
);

FILE: tb/pcme_scoreboard.sv
// Checker of the motion evaluator: predicts each response and compares it field by field.
`timescale 1ns / 1ps
module pcme_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	pcme_req_if.sink    req,
	pcme_rsp_if.sink    rsp,
	output int          fail_count,
	output int          outstanding,
	output int          hit_count,
	output int          checked_count
);

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] position;
		logic [47:0] velocity;
		logic [47:0] acceleration;
		logic [3:0]  segment_index;
	} motion_result_t;

	pcme_pkg::seg_t  seg_table [pcme_pkg::MAX_SEGMENTS];
	int              seg_total;
	motion_result_t  pending_results [$];

	assign outstanding = pending_results.size();

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Rounds num / (c * 2^sh) to nearest, ties upward, then saturates to 48 bits.
	function automatic logic [47:0] round_saturate(input logic signed [255:0] num,
			input int sh, input int c);
		logic signed [255:0] div;
		logic signed [255:0] q;
		div = 256'(c) <<< sh;
		num = num + (div >>> 1);
		if (num < 0) begin
			q = -((-num + div - 1) / div);
		end else begin
			q = num / div;
		end
		if (q > 256'sh7FFF_FFFF_FFFF) begin
			return 48'h7FFF_FFFF_FFFF;
		end
		if (q < -(256'sh8000_0000_0000)) begin
			return 48'h8000_0000_0000;
		end
		return q[47:0];
	endfunction

	// Evaluates the cubic motion of one stored segment at offset dt.
	function automatic motion_result_t evaluate_motion(input pcme_pkg::seg_t s,
			input logic [31:0] dt, input int idx);
		motion_result_t r;
		logic signed [255:0] p, v, a, j, d, n;
		p = $signed(s.position);
		v = $signed(s.velocity);
		a = $signed(s.acceleration);
		j = $signed(s.jerk);
		d = {224'b0, dt};
		r.status = pcme_pkg::STATUS_OK;
		n = ((p * 6) <<< 48) + ((v * 6 * d) <<< 32) + ((a * 3 * d * d) <<< 16) + j * d * d * d;
		r.position = round_saturate(n, 48, 6);
		n = ((v * 2) <<< 32) + ((a * 2 * d) <<< 16) + j * d * d;
		r.velocity = round_saturate(n, 32, 2);
		n = (a <<< 16) + j * d;
		r.acceleration = round_saturate(n, 16, 1);
		r.segment_index = idx[3:0];
		return r;
	endfunction

	// Applies one request to the table copy and returns its response.
	function automatic motion_result_t apply_request();
		motion_result_t r;
		int i;
		r = '0;
		r.status = pcme_pkg::STATUS_OK;
		case (req.operation)
			pcme_pkg::OP_APPEND: begin
				if (seg_total >= pcme_pkg::MAX_SEGMENTS) begin
					r.status = pcme_pkg::STATUS_FULL;
				end else begin
					seg_table[seg_total] = '{req.seg_start_time, req.seg_end_time,
						req.seg_position, req.seg_velocity, req.seg_acceleration, req.seg_jerk};
					seg_total++;
				end
			end
			pcme_pkg::OP_EVAL: begin
				r.status = pcme_pkg::STATUS_NOHIT;
				for (i = 0; i < seg_total; i++) begin
					if (req.query_time >= seg_table[i].t_begin &&
							req.query_time < seg_table[i].t_end) begin
						r = evaluate_motion(seg_table[i],
							req.query_time - seg_table[i].t_begin, i);
						hit_count++;
						break;
					end
				end
			end
			pcme_pkg::OP_TRIM: begin
				if (int'(req.keep_count) < seg_total) begin
					seg_total = req.keep_count;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Responses are checked before the request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		motion_result_t want;
		if (!arst_n) begin
			seg_total = 0;
			pending_results.delete();
			fail_count = 0;
			hit_count = 0;
			checked_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$display("UNEXPECTED response at %0t", $realtime);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					checked_count++;
					if (rsp.status !== want.status) begin
						report_mismatch("status", 48'(rsp.status), 48'(want.status));
					end
					if (rsp.position !== want.position) begin
						report_mismatch("position", rsp.position, want.position);
					end
					if (rsp.velocity !== want.velocity) begin
						report_mismatch("velocity", rsp.velocity, want.velocity);
					end
					if (rsp.acceleration !== want.acceleration) begin
						report_mismatch("acceleration", rsp.acceleration, want.acceleration);
					end
					if (rsp.segment_index !== want.segment_index) begin
						report_mismatch("segment_index", 48'(rsp.segment_index),
							48'(want.segment_index));
					end
				end
			end
			if (req.valid && req.ready) begin
				pending_results.insert(pending_results.size(), apply_request());
			end
		end
	end

endmodule

FILE: tb/tb.sv
// Testbench top of the motion evaluator: reset, request stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   fail_count, outstanding, hit_count, checked_count;
	int   send_idle_pct, recv_stall_pct;
	int   sent_count;
	int   idle_cycles;

	// Times of the segments the table holds, for queries that land inside them.
	logic [31:0] known_start [pcme_pkg::MAX_SEGMENTS];
	logic [31:0] known_end [pcme_pkg::MAX_SEGMENTS];
	int          known_total;

	pcme_req_if req ();
	pcme_rsp_if rsp ();

	piecewise_cubic_motion_evaluator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	pcme_scoreboard i_scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req.sink),
		.rsp           (rsp.sink),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.hit_count     (hit_count),
		.checked_count (checked_count)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Response flow control.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Random 48-bit motion value at a random magnitude.
	function automatic logic [47:0] rand_motion();
		logic signed [47:0] v;
		v = 48'({$urandom, $urandom});
		return v >>> $urandom_range(47, 0);
	endfunction

	// Sends one request and waits until it is accepted.
	task automatic send_request(input logic [1:0] op, input logic [31:0] q,
			input logic [31:0] st, input logic [31:0] en, input logic [47:0] p,
			input logic [47:0] v, input logic [47:0] a, input logic [47:0] j,
			input logic [4:0] keep);
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.query_time <= q;
		req.seg_start_time <= st;
		req.seg_end_time <= en;
		req.seg_position <= p;
		req.seg_velocity <= v;
		req.seg_acceleration <= a;
		req.seg_jerk <= j;
		req.keep_count <= keep;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent_count++;
		// Track the table the same way for query generation.
		if (op == pcme_pkg::OP_APPEND && known_total < pcme_pkg::MAX_SEGMENTS) begin
			known_start[known_total] = st;
			known_end[known_total] = en;
			known_total++;
		end else if (op == pcme_pkg::OP_TRIM && int'(keep) < known_total) begin
			known_total = keep;
		end
	endtask

	task automatic append_seg(input logic [31:0] st, input logic [31:0] en,
			input logic [47:0] p, input logic [47:0] v, input logic [47:0] a,
			input logic [47:0] j);
		send_request(pcme_pkg::OP_APPEND, $urandom, st, en, p, v, a, j, 5'($urandom));
	endtask

	task automatic eval_at(input logic [31:0] q);
		send_request(pcme_pkg::OP_EVAL, q, $urandom, $urandom, rand_motion(), rand_motion(),
			rand_motion(), rand_motion(), 5'($urandom));
	endtask

	task automatic trim_to(input logic [4:0] keep);
		send_request(pcme_pkg::OP_TRIM, $urandom, $urandom, $urandom, rand_motion(),
			rand_motion(), rand_motion(), rand_motion(), keep);
	endtask

	// Random segment, mostly short so that results stay in range.
	task automatic append_random();
		logic [31:0] st, len;
		st = $urandom;
		case ($urandom_range(9))
			0: len = 0;
			1: len = $urandom;
			default: len = $urandom_range(1, 32'h0004_0000);
		endcase
		append_seg(st, st + len, rand_motion(), rand_motion(), rand_motion(), rand_motion());
	endtask

	// Query inside a known segment when there is one.
	task automatic eval_inside();
		int k;
		logic [31:0] span;
		if (known_total == 0 || known_end[0] == known_start[0] && known_total == 1) begin
			eval_at($urandom);
		end else begin
			k = $urandom_range(known_total - 1);
			span = known_end[k] - known_start[k];
			if (known_end[k] <= known_start[k]) begin
				eval_at(known_start[k]);
			end else begin
				eval_at(known_start[k] + ($urandom % span));
			end
		end
	endtask

	initial begin
		int i, phase;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = pcme_pkg::OP_APPEND;
		req.query_time = '0;
		req.seg_start_time = '0;
		req.seg_end_time = '0;
		req.seg_position = '0;
		req.seg_velocity = '0;
		req.seg_acceleration = '0;
		req.seg_jerk = '0;
		req.keep_count = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sent_count = 0;
		known_total = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, unused code, empty and full spans, extremes.
		eval_at(32'h0);
		trim_to(5'd5);
		send_request(pcme_pkg::OP_NONE, $urandom, $urandom, $urandom, '1, '1, '1, '1, 5'h1F);
		append_seg(32'h0, 32'h0, 48'h1, 48'h1, 48'h1, 48'h1);
		append_seg(32'h0, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
			48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
		eval_at(32'h0);
		eval_at(32'hFFFF_FFFE);
		eval_at(32'hFFFF_FFFF);
		append_seg(32'd100, 32'd200, 48'h8000_0000_0000, 48'h8000_0000_0000,
			48'h8000_0000_0000, 48'h8000_0000_0000);
		trim_to(5'd1);
		eval_at(32'd5);
		append_seg(32'h0001_0000, 32'h0003_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
			48'h8000_0000_0000, 48'h8000_0000_0000);
		eval_at(32'h0002_FFFF);
		eval_at(32'h0003_0000);
		append_seg(32'h0, 32'h0010_0000, 48'h0000_0100_0000, 48'hFFFF_FF00_0000,
			48'h0000_0200_0000, 48'hFFFF_FA00_0000);
		eval_at(32'h000F_FFFF);
		// Fill the table, then one append too many.
		for (i = 0; i < 13; i++) append_random();
		append_random();
		trim_to(5'd16);
		trim_to(5'd17);
		trim_to(5'd0);

		// Random part in four flow-control phases.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 70; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 70; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			for (i = 0; i < 310; i++) begin
				case ($urandom_range(19))
					0: trim_to($urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(4)));
					1: eval_at($urandom);
					2: send_request(pcme_pkg::OP_NONE, $urandom, $urandom, $urandom,
						rand_motion(), rand_motion(), rand_motion(), rand_motion(),
						5'($urandom));
					3, 4, 5, 6, 7, 8, 9: append_random();
					default: eval_inside();
				endcase
			end
		end
		req.valid <= 1'b0;

		// Drain and let the block settle.
		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Sent %0d requests, checked %0d responses, %0d of them evaluate hits.",
			sent_count, checked_count, hit_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
